@@ sv/sdfc_pkg.sv @@
package sdfc_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned StiffW = 24;
  localparam int unsigned DampW  = 20;
  localparam int unsigned LimW   = 24;
  localparam int unsigned ForceW = 32;
  localparam int unsigned SqW    = 2 * ForceW;
  localparam int unsigned ProdW  = ForceW + LimW;
  localparam int unsigned Axes   = 3;

  // force: 3 stages, magnitude: 2 + 32, scaling: 1 + 32, output register: 1
  localparam int unsigned SqrtSteps = ForceW;
  localparam int unsigned DivSteps  = ForceW;
  localparam int unsigned Latency   = 3 + 2 + SqrtSteps + 1 + DivSteps + 1;

  typedef enum logic [1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_FORCE_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [StiffW-1:0] stiffness;
    logic [DampW-1:0]  damping;
    logic [LimW-1:0]   force_limit;
  } cfg_t;

  // force components travelling alongside the magnitude and scaling pipes
  typedef struct packed {
    logic                          clamp;
    logic [Axes-1:0][ForceW-1:0]   f;
  } sb_t;

endpackage

@@ sv/spring_damper_force_clamp_top.sv @@
// channel  | direction | handshake            | payload
// input    | in        | start_i, busy_o      | tool_*_i, goal_*_i, vel_*_i
// result   | out       | done_o (one cycle)   | force_*_o, clamped_o
// config   | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// an item enters in every cycle; busy_o stays low
// each result passes the force stages, the 32-step root pipe and the
// 32-step divider pipe, one bit per stage, and then the output register
// reset clears the stage valid bits and the config registers; no clearing pass
// the receiver cannot stall, so nothing in the pipe ever holds
module spring_damper_force_clamp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] tool_x_i,
  input  logic [23:0] tool_y_i,
  input  logic [23:0] tool_z_i,
  input  logic [23:0] goal_x_i,
  input  logic [23:0] goal_y_i,
  input  logic [23:0] goal_z_i,
  input  logic [23:0] vel_x_i,
  input  logic [23:0] vel_y_i,
  input  logic [23:0] vel_z_i,
  output logic        done_o,
  output logic [31:0] force_x_o,
  output logic [31:0] force_y_o,
  output logic [31:0] force_z_o,
  output logic        clamped_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  sdfc_pkg::cfg_t  cfg_q;
  sdfc_pkg::cfg_t  cfg_d;
  logic            acc;
  logic            fv;
  logic [2:0][31:0] f;
  sdfc_pkg::sb_t   sb_f;
  logic            mv;
  sdfc_pkg::sb_t   sb_m;
  logic [31:0]     mag;
  logic            dv;
  sdfc_pkg::sb_t   sb_v;
  logic [2:0][31:0] quo;
  logic [2:0][31:0] res_d;
  logic [2:0][31:0] res_q;
  logic            clamp_q;
  logic            done_q;

  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sdfc_pkg::cfg_idx_e'(cfg_idx_i))
        sdfc_pkg::CFG_STIFFNESS:   cfg_d.stiffness   = cfg_data_i;
        sdfc_pkg::CFG_DAMPING:     cfg_d.damping     = cfg_data_i[19:0];
        sdfc_pkg::CFG_FORCE_LIMIT: cfg_d.force_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      done_q <= dv;
    end
  end

  sdfc_force u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .cfg_i   (cfg_q),
    .tool_i  ({tool_z_i, tool_y_i, tool_x_i}),
    .goal_i  ({goal_z_i, goal_y_i, goal_x_i}),
    .vel_i   ({vel_z_i, vel_y_i, vel_x_i}),
    .valid_o (fv),
    .f_o     (f)
  );

  assign sb_f.clamp = 1'b0;
  assign sb_f.f     = f;

  sdfc_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .sb_i    (sb_f),
    .limit_i (cfg_q.force_limit),
    .valid_o (mv),
    .sb_o    (sb_m),
    .mag_o   (mag)
  );

  sdfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mv),
    .sb_i    (sb_m),
    .mag_i   (mag),
    .limit_i (cfg_q.force_limit),
    .valid_o (dv),
    .sb_o    (sb_v),
    .q_o     (quo)
  );

  // scaled size gets the sign of the original component back
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (sb_v.clamp) begin
        res_d[j] = sb_v.f[j][31] ? 32'(-quo[j]) : quo[j];
      end else begin
        res_d[j] = sb_v.f[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    clamp_q <= sb_v.clamp;
  end

  assign done_o    = done_q;
  assign force_x_o = res_q[0];
  assign force_y_o = res_q[1];
  assign force_z_o = res_q[2];
  assign clamped_o = clamp_q;

endmodule

@@ sv/sdfc_force.sv @@
module sdfc_force (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  valid_i,
  input  sdfc_pkg::cfg_t                                        cfg_i,
  input  logic [sdfc_pkg::Axes-1:0][sdfc_pkg::PosW-1:0]         tool_i,
  input  logic [sdfc_pkg::Axes-1:0][sdfc_pkg::PosW-1:0]         goal_i,
  input  logic [sdfc_pkg::Axes-1:0][sdfc_pkg::PosW-1:0]         vel_i,
  output logic                                                  valid_o,
  output logic [sdfc_pkg::Axes-1:0][sdfc_pkg::ForceW-1:0]       f_o
);

  logic [2:0]         v_q;
  logic signed [24:0] diff_d [3];
  logic signed [24:0] diff_q [3];
  logic signed [23:0] vel_q  [3];
  logic signed [49:0] sp_d   [3];
  logic signed [49:0] sp_q   [3];
  logic signed [44:0] dp_d   [3];
  logic signed [44:0] dp_q   [3];
  logic signed [50:0] s_d    [3];
  logic signed [42:0] sh_d   [3];
  logic [31:0]        f_d    [3];
  logic [31:0]        f_q    [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff_d[j] = $signed({goal_i[j][23], goal_i[j]}) - $signed({tool_i[j][23], tool_i[j]});
      sp_d[j]   = $signed({1'b0, cfg_i.stiffness}) * diff_q[j];
      dp_d[j]   = $signed({1'b0, cfg_i.damping}) * vel_q[j];
      s_d[j]    = $signed({sp_q[j][49], sp_q[j]}) - $signed({{6{dp_q[j][44]}}, dp_q[j]});
      // floor shift by 8 back to sixteen fraction bits
      sh_d[j]   = s_d[j][50:8];
      if (!sh_d[j][42] && (sh_d[j][41:31] != 11'd0)) begin
        f_d[j] = 32'h7fff_ffff;
      end else if (sh_d[j][42] && (sh_d[j][41:31] != 11'h7ff)) begin
        f_d[j] = 32'h8000_0000;
      end else begin
        f_d[j] = sh_d[j][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 3'b000;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      diff_q[j] <= diff_d[j];
      vel_q[j]  <= vel_i[j];
      sp_q[j]   <= sp_d[j];
      dp_q[j]   <= dp_d[j];
      f_q[j]    <= f_d[j];
    end
  end

  assign valid_o = v_q[2];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      f_o[j] = f_q[j];
    end
  end

endmodule

@@ sv/sdfc_mag.sv @@
module sdfc_mag (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  sdfc_pkg::sb_t                     sb_i,
  input  logic [sdfc_pkg::LimW-1:0]         limit_i,
  output logic                              valid_o,
  output sdfc_pkg::sb_t                     sb_o,
  output logic [sdfc_pkg::ForceW-1:0]       mag_o
);

  localparam int unsigned N = sdfc_pkg::SqrtSteps;

  logic [31:0]         absf   [3];
  logic [63:0]         sq_d   [3];
  logic [63:0]         sq_q   [3];
  logic                v0_q;
  logic                v1_q;
  sdfc_pkg::sb_t       sb0_q;
  sdfc_pkg::sb_t       sb1_d;
  sdfc_pkg::sb_t       sb1_q;
  logic [63:0]         sum_d;
  logic [63:0]         sum_q;
  logic [47:0]         lim2_q;

  logic [N-1:0]        vp_q;
  sdfc_pkg::sb_t       sbp_q  [N];
  logic [32:0]         rem_d  [N];
  logic [32:0]         rem_q  [N];
  logic [31:0]         root_d [N];
  logic [31:0]         root_q [N];
  logic [63:0]         rad_d  [N];
  logic [63:0]         rad_q  [N];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      absf[j] = sb_i.f[j][31] ? 32'(-sb_i.f[j]) : sb_i.f[j];
      sq_d[j] = absf[j] * absf[j];
    end
    sum_d       = sq_q[0] + sq_q[1] + sq_q[2];
    sb1_d       = sb0_q;
    sb1_d.clamp = sum_d > {16'd0, lim2_q};
  end

  // one root bit per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [32:0] r;
      logic [31:0] rt;
      logic [63:0] rd;
      logic [34:0] t;
      logic [34:0] trial;
      if (k == 0) begin
        r  = '0;
        rt = '0;
        rd = sum_q;
      end else begin
        r  = rem_q[k-1];
        rt = root_q[k-1];
        rd = rad_q[k-1];
      end
      t     = {r[32:0], rd[63:62]};
      trial = {1'b0, rt, 2'b01};
      if (t >= trial) begin
        rem_d[k]  = 33'(t - trial);
        root_d[k] = {rt[30:0], 1'b1};
      end else begin
        rem_d[k]  = t[32:0];
        root_d[k] = {rt[30:0], 1'b0};
      end
      rad_d[k] = {rd[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vp_q <= '0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      vp_q <= {vp_q[N-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      sq_q[j] <= sq_d[j];
    end
    sb0_q  <= sb_i;
    sb1_q  <= sb1_d;
    sum_q  <= sum_d;
    lim2_q <= limit_i * limit_i;
    for (int k = 0; k < N; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      rad_q[k]  <= rad_d[k];
      sbp_q[k]  <= (k == 0) ? sb1_q : sbp_q[(k == 0) ? 0 : k-1];
    end
  end

  assign valid_o = vp_q[N-1];
  assign sb_o    = sbp_q[N-1];
  assign mag_o   = root_q[N-1];

endmodule

@@ sv/sdfc_div.sv @@
module sdfc_div (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  sdfc_pkg::sb_t                                   sb_i,
  input  logic [sdfc_pkg::ForceW-1:0]                     mag_i,
  input  logic [sdfc_pkg::LimW-1:0]                       limit_i,
  output logic                                            valid_o,
  output sdfc_pkg::sb_t                                   sb_o,
  output logic [sdfc_pkg::Axes-1:0][sdfc_pkg::ForceW-1:0] q_o
);

  localparam int unsigned N = sdfc_pkg::DivSteps;

  logic [31:0]         absf  [3];
  logic [55:0]         prod_d [3];
  logic [55:0]         prod_q [3];
  logic                v0_q;
  sdfc_pkg::sb_t       sb0_q;
  logic [31:0]         mag0_q;

  logic [N-1:0]        vp_q;
  sdfc_pkg::sb_t       sbp_q  [N];
  logic [31:0]         magp_q [N];
  logic [31:0]         rem_d  [N][3];
  logic [31:0]         rem_q  [N][3];
  logic [31:0]         num_d  [N][3];
  logic [31:0]         num_q  [N][3];
  logic [31:0]         quo_d  [N][3];
  logic [31:0]         quo_q  [N][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      absf[j]   = sb_i.f[j][31] ? 32'(-sb_i.f[j]) : sb_i.f[j];
      prod_d[j] = absf[j] * limit_i;
    end
  end

  // restoring division, one quotient bit per stage; the quotient of a clamped
  // item fits 32 bits, so the top of the product starts as remainder
  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int j = 0; j < 3; j++) begin
        logic [31:0] r;
        logic [31:0] nm;
        logic [31:0] qq;
        logic [31:0] dv;
        logic [32:0] t;
        if (k == 0) begin
          r  = {8'd0, prod_q[j][55:32]};
          nm = prod_q[j][31:0];
          qq = '0;
          dv = mag0_q;
        end else begin
          r  = rem_q[k-1][j];
          nm = num_q[k-1][j];
          qq = quo_q[k-1][j];
          dv = magp_q[k-1];
        end
        t = {r, nm[31]};
        if (t >= {1'b0, dv}) begin
          rem_d[k][j] = 32'(t - {1'b0, dv});
          quo_d[k][j] = {qq[30:0], 1'b1};
        end else begin
          rem_d[k][j] = t[31:0];
          quo_d[k][j] = {qq[30:0], 1'b0};
        end
        num_d[k][j] = {nm[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vp_q <= '0;
    end else begin
      v0_q <= valid_i;
      vp_q <= {vp_q[N-2:0], v0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      prod_q[j] <= prod_d[j];
    end
    sb0_q  <= sb_i;
    mag0_q <= mag_i;
    for (int k = 0; k < N; k++) begin
      sbp_q[k]  <= (k == 0) ? sb0_q  : sbp_q[(k == 0) ? 0 : k-1];
      magp_q[k] <= (k == 0) ? mag0_q : magp_q[(k == 0) ? 0 : k-1];
      for (int j = 0; j < 3; j++) begin
        rem_q[k][j] <= rem_d[k][j];
        num_q[k][j] <= num_d[k][j];
        quo_q[k][j] <= quo_d[k][j];
      end
    end
  end

  assign valid_o = vp_q[N-1];
  assign sb_o    = sbp_q[N-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      q_o[j] = quo_q[N-1][j];
    end
  end

endmodule

@@ sv/sdfc_checker.sv @@
module sdfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o
);

  // every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(sdfc_pkg::Latency) done_o)
    else $error("item lost in pipe");

  // no result without an item accepted the fixed latency before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, sdfc_pkg::Latency))
    else $error("result without item");

  // the pipe never holds the input side off
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind spring_damper_force_clamp_top sdfc_checker u_sdfc_checker (.*);

@@ tb/sv/tb_spring_damper_force_clamp_top.sv @@
`timescale 1ns / 100ps

module tb_spring_damper_force_clamp_top;

  typedef struct packed {
    logic [sdfc_pkg::PosW-1:0] tx, ty, tz, gx, gy, gz, vx, vy, vz;
  } pose_t;

  typedef struct packed {
    logic [sdfc_pkg::ForceW-1:0] fx, fy, fz;
    logic                        clamp;
  } force_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [23:0] tool_x_i = '0, tool_y_i = '0, tool_z_i = '0;
  logic [23:0] goal_x_i = '0, goal_y_i = '0, goal_z_i = '0;
  logic [23:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic        done_o;
  logic [31:0] force_x_o, force_y_o, force_z_o;
  logic        clamped_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  spring_damper_force_clamp_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [sdfc_pkg::StiffW-1:0] k_spring = '0;
  logic [sdfc_pkg::DampW-1:0]  k_damp = '0;
  logic [sdfc_pkg::LimW-1:0]   f_limit = '0;

  pose_t  pending_items[$];
  force_t expected_forces[$];
  int     n_items = 0, n_forces = 0, n_clamped = 0, n_mismatch = 0, idle_cycles = 0;
  bit     no_gaps = 1'b0;
  int     gap_left = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic force_t spring_force(pose_t p);
    logic signed [sdfc_pkg::PosW-1:0] tl[3], gl[3], vl[3];
    longint  f[3];
    longint  d;
    longint unsigned a, sumsq = 0, lim2, mag, q;
    force_t  r;
    tl = '{p.tx, p.ty, p.tz};
    gl = '{p.gx, p.gy, p.gz};
    vl = '{p.vx, p.vy, p.vz};
    for (int i = 0; i < 3; i++) begin
      d = longint'(k_spring) * (longint'(gl[i]) - longint'(tl[i]))
          - longint'(k_damp) * longint'(vl[i]);
      d = d >>> 8;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      f[i] = d;
      a = (d < 0) ? -d : d;
      sumsq += a * a;
    end
    lim2 = longint'(f_limit) * longint'(f_limit);
    r.clamp = sumsq > lim2;
    if (r.clamp) begin
      mag = root_floor(sumsq);
      for (int i = 0; i < 3; i++) begin
        a = (f[i] < 0) ? -f[i] : f[i];
        q = (a * f_limit) / mag;
        f[i] = (f[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    r.fx = f[0][31:0];
    r.fy = f[1][31:0];
    r.fz = f[2][31:0];
    return r;
  endfunction

  task automatic write_reg(sdfc_pkg::cfg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sdfc_pkg::CFG_STIFFNESS:   k_spring = val;
      sdfc_pkg::CFG_DAMPING:     k_damp = val[sdfc_pkg::DampW-1:0];
      sdfc_pkg::CFG_FORCE_LIMIT: f_limit = val;
      default: ;
    endcase
  endtask

  // wait until the pipe is empty before touching the registers
  task automatic drain();
    while (pending_items.size() != 0 || expected_forces.size() != 0) @(posedge clk_i);
    repeat (sdfc_pkg::Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_pos(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom_range(0, 65535) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose(int mode);
    pose_t p;
    p.tx = rand_pos($urandom_range(0, mode)); p.ty = rand_pos($urandom_range(0, mode));
    p.tz = rand_pos($urandom_range(0, mode)); p.gx = rand_pos($urandom_range(0, mode));
    p.gy = rand_pos($urandom_range(0, mode)); p.gz = rand_pos($urandom_range(0, mode));
    p.vx = rand_pos($urandom_range(0, mode)); p.vy = rand_pos($urandom_range(0, mode));
    p.vz = rand_pos($urandom_range(0, mode));
    return p;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_forces.push_back(spring_force(pending_items.pop_front()));
      n_items++;
    end
    if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(0, 11);
      start_i <= 1'b0;
    end else if (rst_ni && pending_items.size() > 0 && !(start_i && !busy_o &&
                 pending_items.size() == 0)) begin
      {tool_x_i, tool_y_i, tool_z_i, goal_x_i, goal_y_i, goal_z_i,
       vel_x_i, vel_y_i, vel_z_i} <= pending_items[0];
      start_i <= 1'b1;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    force_t want;
    if (done_o) begin
      n_forces++;
      if (clamped_o) n_clamped++;
      if (expected_forces.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h %h %h %b",
                                       force_x_o, force_y_o, force_z_o, clamped_o);
      end else begin
        want = expected_forces.pop_front();
        if ({force_x_o, force_y_o, force_z_o, clamped_o} !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", want.fx, want.fy,
                     want.fz, want.clamp, force_x_o, force_y_o, force_z_o, clamped_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (done_o || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("[spring_damper_force_clamp_top] ERROR");
      $finish;
    end
  end

  typedef struct { logic [23:0] k, d, l; } setting_t;

  initial begin
    setting_t sets[6];
    pose_t p;
    sets[0] = '{24'd0, 24'd0, 24'd0};
    sets[1] = '{24'hffffff, 24'hfffff, 24'hffffff};
    sets[2] = '{24'd256, 24'd0, 24'd0};
    sets[3] = '{24'h001000, 24'h00800, 24'h040000};
    sets[4] = '{24'h000100, 24'h00100, 24'h030000};
    sets[5] = '{24'h00ffff, 24'h0ffff, 24'h800000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed part under a nonzero limit and under zero limit
    write_reg(sdfc_pkg::CFG_STIFFNESS, 24'h000100);
    write_reg(sdfc_pkg::CFG_DAMPING, 24'h00100);
    write_reg(sdfc_pkg::CFG_FORCE_LIMIT, 24'h050000);
    p = '0; pending_items.push_back(p);
    // 3-4-5 triangle: magnitude equals the limit, not clamped
    p.gx = 24'h030000; p.gy = 24'h040000; pending_items.push_back(p);
    // just above the limit: root floor equals the limit, clamped and unchanged
    p.gz = 24'h000001; pending_items.push_back(p);
    p = '0; p.gx = 24'h100000; pending_items.push_back(p);
    p = {9{24'h7fffff}}; pending_items.push_back(p);
    p = {9{24'h800000}}; pending_items.push_back(p);
    p = '0; p.tx = 24'h7fffff; p.gx = 24'h800000; p.vy = 24'h800000; p.vz = 24'h7fffff;
    pending_items.push_back(p);
    p = '0; p.tx = 24'h800000; p.gx = 24'h7fffff; p.vy = 24'h7fffff;
    pending_items.push_back(p);
    drain();
    write_reg(sdfc_pkg::CFG_FORCE_LIMIT, 24'h0);
    p = '0; pending_items.push_back(p);
    p.vx = 24'h000005; pending_items.push_back(p);
    drain();
    // saturation at the extremes of both coefficients
    write_reg(sdfc_pkg::CFG_STIFFNESS, 24'hffffff);
    write_reg(sdfc_pkg::CFG_DAMPING, 24'hfffff);
    write_reg(sdfc_pkg::CFG_FORCE_LIMIT, 24'hffffff);
    for (int i = 0; i < 6; i++) pending_items.push_back(rand_pose(1));
    drain();
    // random part over several settings
    for (int s = 0; s < 6; s++) begin
      write_reg(sdfc_pkg::CFG_STIFFNESS, sets[s].k);
      write_reg(sdfc_pkg::CFG_DAMPING, sets[s].d);
      write_reg(sdfc_pkg::CFG_FORCE_LIMIT, sets[s].l);
      if (s == 5) no_gaps = 1'b1;
      for (int i = 0; i < 80; i++) pending_items.push_back(rand_pose(3));
      drain();
    end
    write_reg(sdfc_pkg::CFG_STIFFNESS, 24'($urandom));
    write_reg(sdfc_pkg::CFG_DAMPING, 24'($urandom));
    write_reg(sdfc_pkg::CFG_FORCE_LIMIT, 24'($urandom));
    for (int i = 0; i < 20; i++) pending_items.push_back(rand_pose(3));
    drain();
    $display("items %0d, results %0d (%0d clamped) over ten register settings",
             n_items, n_forces, n_clamped);
    $display("mismatches %0d", n_mismatch);
    if (n_mismatch == 0 && expected_forces.size() == 0)
      $display("[spring_damper_force_clamp_top] OK");
    else
      $display("[spring_damper_force_clamp_top] ERROR");
    $finish;
  end

endmodule
